// ===== hdl/cdps_pkg.sv =====
// ----------------------------------------------------------------------------
// cdps_pkg
// Shared types and constants for the compressor drive PWM sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cdps_pkg;

    // divider geometry: 66666666 needs 26 bits, divisors stay within 16 bits
    localparam int unsigned DIVIDEND_W = 26;
    localparam int unsigned DIVISOR_W  = 16;
    localparam int unsigned ITER_W     = 5;
    localparam int unsigned PHASE_W    = 4;

    localparam logic [DIVIDEND_W-1:0] PERIOD_NUMER = 26'd66666666;
    localparam logic [15:0]           TOP_RESET    = 16'd51400;
    localparam logic [15:0]           FREQ_LOW     = 16'd1050;
    localparam logic [15:0]           FREQ_HIGH    = 16'd1700;
    localparam logic [7:0]            FULL_REQ     = 8'd254;
    localparam logic [15:0]           TENTH_DIV    = 16'd10;
    localparam logic [15:0]           SCALE_DIV    = 16'd510;

    // reciprocals rounded up: 2^19/10 and 2^32/510; 2936017 lies above 7*2^22/10
    localparam logic [15:0] TENTH_MUL       = 16'd52429;
    localparam logic [21:0] SEVEN_TENTH_MUL = 22'd2936017;
    localparam logic [23:0] SCALE_MUL       = 24'd8421505;

    // quotient bits computed for the period division
    localparam logic [ITER_W-1:0] ITER_FREQ = 5'd26;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_FREQ_WAIT,
        ST_LEVEL,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic take;
        logic div_start;
        logic write_top;
        logic level_off;
        logic level_full;
        logic save_seven;
        logic level_part;
        logic tick;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_fire;
        logic is_tick;
        logic code_ok;
        logic req_zero;
        logic req_full;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== hdl/cdps_if.sv =====
// ----------------------------------------------------------------------------
// cdps_if
// Valid/ready channels for setpoint and tick items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdps_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  request;
    logic [15:0] freq_code;
    logic        measuring;

    modport source (output valid, kind, request, freq_code, measuring, input ready);
    modport sink   (input valid, kind, request, freq_code, measuring, output ready);
endinterface

interface cdps_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] period_top;
    logic [15:0] compare_level;
    logic        drive_a_on;
    logic        drive_b_on;
    logic        protect_on;
    logic        tick_enable;
    logic [3:0]  phase_now;

    modport source (output valid, period_top, compare_level, drive_a_on, drive_b_on,
                    protect_on, tick_enable, phase_now, input ready);
    modport sink   (input valid, period_top, compare_level, drive_a_on, drive_b_on,
                    protect_on, tick_enable, phase_now, output ready);
endinterface

`default_nettype wire

// ===== hdl/cdps_divider.sv =====
// ----------------------------------------------------------------------------
// cdps_divider
// Restoring divider, one quotient bit per cycle, with a per-job bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module cdps_divider (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [cdps_pkg::DIVIDEND_W-1:0]     dividend,
    input  wire logic [cdps_pkg::DIVISOR_W-1:0]      divisor,
    input  wire logic [cdps_pkg::ITER_W-1:0]         iters,
    output logic                                     busy,
    output logic                                     done,
    output logic [cdps_pkg::DIVIDEND_W-1:0]          quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [cdps_pkg::ITER_W-1:0]       count_reg, count_next;
    logic [cdps_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [cdps_pkg::DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [cdps_pkg::DIVISOR_W-1:0]    dsr_reg, dsr_next;
    logic [cdps_pkg::DIVISOR_W:0]      trial;
    logic [cdps_pkg::DIVISOR_W:0]      diff;
    logic                              fits;
    logic [cdps_pkg::ITER_W-1:0]       align;

    assign trial = {rem_reg, quo_reg[cdps_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign align = cdps_pkg::ITER_W'(cdps_pkg::DIVIDEND_W) - iters;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            // park the dividend in the top bits so only iters steps are needed
            busy_next  = 1'b1;
            count_next = iters;
            rem_next   = '0;
            quo_next   = dividend << align;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[cdps_pkg::DIVISOR_W-1:0]
                              : trial[cdps_pkg::DIVISOR_W-1:0];
            quo_next   = {quo_reg[cdps_pkg::DIVIDEND_W-2:0], fits};
            count_next = count_reg - 1'b1;
            if (count_reg == cdps_pkg::ITER_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/cdps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdps_ctrl
// Sequencer for item intake, divider jobs, state updates and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module cdps_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cdps_pkg::status_t status,
    output cdps_pkg::cmd_t         cmd
);

    cdps_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdps_pkg::ST_IDLE:
            begin
                if (status.in_fire)
                    state_next = cdps_pkg::ST_DECODE;
            end
            cdps_pkg::ST_DECODE:
            begin
                if (status.is_tick)
                    state_next = cdps_pkg::ST_TICK;
                else if (status.code_ok)
                    state_next = cdps_pkg::ST_FREQ_WAIT;
                else
                    state_next = cdps_pkg::ST_LEVEL;
            end
            cdps_pkg::ST_TICK:
                state_next = cdps_pkg::ST_DONE;
            cdps_pkg::ST_FREQ_WAIT:
            begin
                if (status.div_done)
                    state_next = cdps_pkg::ST_LEVEL;
            end
            cdps_pkg::ST_LEVEL:
            begin
                if (status.req_zero || status.req_full)
                    state_next = cdps_pkg::ST_DONE;
                else
                    state_next = cdps_pkg::ST_SCALE;
            end
            cdps_pkg::ST_SCALE:
                state_next = cdps_pkg::ST_DONE;
            cdps_pkg::ST_DONE:
            begin
                if (status.out_free)
                    state_next = cdps_pkg::ST_IDLE;
            end
            default:
                state_next = cdps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            cdps_pkg::ST_IDLE:
                cmd.take = 1'b1;
            cdps_pkg::ST_DECODE:
                cmd.div_start = !status.is_tick && status.code_ok;
            cdps_pkg::ST_TICK:
                cmd.tick = 1'b1;
            cdps_pkg::ST_FREQ_WAIT:
                cmd.write_top = status.div_done;
            cdps_pkg::ST_LEVEL:
            begin
                cmd.level_off  = status.req_zero;
                cmd.level_full = !status.req_zero && status.req_full;
                cmd.save_seven = !status.req_zero && !status.req_full;
            end
            cdps_pkg::ST_SCALE:
                cmd.level_part = 1'b1;
            cdps_pkg::ST_DONE:
                cmd.emit = status.out_free;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cdps_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hdl/cdps_datapath.sv =====
// ----------------------------------------------------------------------------
// cdps_datapath
// Drive state, period divider, reciprocal level arithmetic and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdps_datapath #(
    parameter int unsigned PHASE_PERIOD = 12
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cdps_in_if.sink                feed,
    cdps_out_if.source             result,
    input  wire cdps_pkg::cmd_t    cmd,
    output cdps_pkg::status_t      status
);

    localparam int unsigned PW      = $clog2(PHASE_PERIOD + 1);
    localparam int unsigned QUARTER = PHASE_PERIOD / 4;

    // captured item
    logic        kind_reg;
    logic [7:0]  req_reg;
    logic [15:0] code_reg;
    logic        meas_reg;

    // drive state
    logic [15:0]   top_reg, top_next;
    logic [15:0]   compare_reg, compare_next;
    logic [PW-1:0] phase_reg, phase_next;
    logic          a_reg, a_next;
    logic          b_reg, b_next;
    logic          prot_reg, prot_next;
    logic          tick_reg, tick_next;

    // intermediate terms of the partial drive level
    logic [15:0] seven_reg;
    logic [23:0] prod_reg;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_top_reg;
    logic [15:0] out_cmp_reg;
    logic        out_a_reg;
    logic        out_b_reg;
    logic        out_prot_reg;
    logic        out_tick_reg;
    logic [3:0]  out_phase_reg;

    logic [cdps_pkg::DIVIDEND_W-1:0] div_dividend;
    logic [cdps_pkg::DIVISOR_W-1:0]  div_divisor;
    logic [cdps_pkg::ITER_W-1:0]     div_iters;
    logic                            div_busy;
    logic                            div_done;
    logic [cdps_pkg::DIVIDEND_W-1:0] div_quotient;
    logic [15:0]                     quo16;
    logic [34:0]                     tenth_prod;
    logic [37:0]                     seven_prod;
    logic [47:0]                     scale_prod;
    logic [PW-1:0]                   phase_base;

    assign quo16 = div_quotient[15:0];

    // divisions by 10 and 510 as reciprocal multiplies, exact over the operand ranges
    assign tenth_prod = 35'(top_reg) * 35'(cdps_pkg::TENTH_MUL);
    assign seven_prod = 38'(top_reg) * 38'(cdps_pkg::SEVEN_TENTH_MUL);
    assign scale_prod = 48'(prod_reg) * 48'(cdps_pkg::SCALE_MUL);

    assign div_dividend = cdps_pkg::PERIOD_NUMER;
    assign div_divisor  = code_reg;
    assign div_iters    = cdps_pkg::ITER_FREQ;

    cdps_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // the counter sits at the period end until the next enabled tick wraps it
    assign phase_base = (phase_reg == PW'(PHASE_PERIOD)) ? '0 : phase_reg;

    always_comb
    begin
        top_next     = top_reg;
        compare_next = compare_reg;
        phase_next   = phase_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        prot_next    = prot_reg;
        tick_next    = tick_reg;
        if (cmd.write_top)
            top_next = quo16;
        if (cmd.level_off)
        begin
            compare_next = '0;
            a_next       = 1'b0;
            b_next       = 1'b0;
            prot_next    = 1'b1;
            tick_next    = 1'b0;
        end
        if (cmd.level_full)
        begin
            compare_next = tenth_prod[34:19];
            prot_next    = 1'b0;
            tick_next    = 1'b1;
        end
        if (cmd.level_part)
        begin
            compare_next = seven_reg - scale_prod[47:32];
            prot_next    = 1'b1;
            tick_next    = 1'b1;
        end
        if (cmd.tick && tick_reg)
        begin
            if (phase_base == '0)
            begin
                a_next = 1'b0;
                if (!meas_reg)
                    b_next = 1'b1;
            end
            else if (phase_base == PW'(QUARTER) || phase_base == PW'(3 * QUARTER))
            begin
                a_next = 1'b0;
                b_next = 1'b0;
            end
            else if (phase_base == PW'(2 * QUARTER))
            begin
                b_next = 1'b0;
                if (!meas_reg)
                    a_next = 1'b1;
            end
            phase_next = phase_base + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= cdps_pkg::TOP_RESET;
            compare_reg   <= '0;
            phase_reg     <= '0;
            a_reg         <= 1'b0;
            b_reg         <= 1'b0;
            prot_reg      <= 1'b1;
            tick_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg     <= top_next;
            compare_reg <= compare_next;
            phase_reg   <= phase_next;
            a_reg       <= a_next;
            b_reg       <= b_next;
            prot_reg    <= prot_next;
            tick_reg    <= tick_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.in_fire)
        begin
            kind_reg <= feed.kind;
            req_reg  <= feed.request;
            code_reg <= feed.freq_code;
            meas_reg <= feed.measuring;
        end
        if (cmd.save_seven)
        begin
            seven_reg <= seven_prod[37:22];
            prod_reg  <= req_reg * top_reg;
        end
        if (cmd.emit)
        begin
            out_top_reg   <= top_reg;
            out_cmp_reg   <= compare_reg;
            out_a_reg     <= a_reg;
            out_b_reg     <= b_reg;
            out_prot_reg  <= prot_reg;
            out_tick_reg  <= tick_reg;
            out_phase_reg <= 4'(phase_reg);
        end
    end

    assign feed.ready = cmd.take;

    assign status.in_fire  = feed.valid && cmd.take;
    assign status.is_tick  = kind_reg;
    assign status.code_ok  = (code_reg > cdps_pkg::FREQ_LOW) && (code_reg < cdps_pkg::FREQ_HIGH);
    assign status.req_zero = (req_reg == '0);
    assign status.req_full = (req_reg >= cdps_pkg::FULL_REQ);
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || result.ready;

    assign result.valid         = out_valid_reg;
    assign result.period_top    = out_top_reg;
    assign result.compare_level = out_cmp_reg;
    assign result.drive_a_on    = out_a_reg;
    assign result.drive_b_on    = out_b_reg;
    assign result.protect_on    = out_prot_reg;
    assign result.tick_enable   = out_tick_reg;
    assign result.phase_now     = out_phase_reg;

`ifndef ASSERT_OFF
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PW'(PHASE_PERIOD))
        else $error("phase counter beyond period");

    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(a_reg && b_reg))
        else $error("both drive outputs connected");

    a_unprotected_runs: assert property (@(posedge clk) disable iff (!rst_n)
        !prot_reg |-> tick_reg)
        else $error("protection off while ticks disabled");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted item not presented");
`endif

endmodule

`default_nettype wire

// ===== hdl/compressor_drive_pwm_sequencer.sv =====
// Sequence: an accepted item is decoded, then handled as a period tick or as a level
// update, with an extra scale step for a partial drive level; a valid frequency code
// first adds a division of the period constant, one quotient bit per cycle.
// Intake: one item at a time; the next item is taken the cycle after its result
// enters the output register.
// Reset gives period 51400, compare 0, outputs off, protection on, ticks off.
// ----------------------------------------------------------------------------
// compressor_drive_pwm_sequencer
// PWM period, compare level and phase sequencing for a two-phase compressor.
// ----------------------------------------------------------------------------
`default_nettype none

module compressor_drive_pwm_sequencer #(
    parameter int unsigned PHASE_PERIOD = 12
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cdps_in_if.sink    feed,
    cdps_out_if.source result
);

    cdps_pkg::cmd_t    cmd;
    cdps_pkg::status_t status;

    cdps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    cdps_datapath #(
        .PHASE_PERIOD (PHASE_PERIOD)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire
